>>> rtl/bra_pkg.sv
package bra_pkg;

   // fixed field widths of the request and response transactions
   localparam int OP_W   = 2;
   localparam int POS_W  = 10;
   localparam int LEN_W  = 11;

   // bit index inside one bitmap word (words are at most 64 bits)
   localparam int IDX_W  = 6;

   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 2;

   // request operation codes
   localparam logic [OP_W-1:0] OP_SCAN  = 2'd0;
   localparam logic [OP_W-1:0] OP_SET   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_MARK  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   // per-word scan outcome
   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] index;
      logic [LEN_W-1:0] carry;
   } scan_result_type;

endpackage

>>> rtl/bitmap_run_allocator_top.sv
// first-fit bitmap run allocator over a MAP_WORDS x WORD_BITS map held in one ram
// set and clear sweep every ram word; a scan reads the words from word 0 upwards and stops
//   at the first hit or after the last word; a rejected or unknown request goes straight to response
// one request at a time: req_tready is low from accept until the response is loaded, which
//   waits while a previous response is stalled; reset: synchronous, then a clearing pass
//   that zeroes every word, with req_tready low
module bitmap_run_allocator_top import bra_pkg::*; #(
   parameter int MAP_WORDS = 16,
   parameter int WORD_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // start_position [9:0], run_length [20:10]
   input  logic [REQ_USER_W-1:0] req_tuser,  // op [1:0]
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // position [9:0]
   output logic [RSP_USER_W-1:0] rsp_tuser   // found [0], range_error [1]
);

   localparam int TOTAL_BITS = MAP_WORDS * WORD_BITS;
   localparam int AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int IW   = $clog2(MAP_WORDS + 1);
   localparam int TB_W = $clog2(TOTAL_BITS + 1);
   // wide enough for map bit counts and for start + length
   localparam int EW   = (TB_W > LEN_W + 1) ? TB_W : LEN_W + 1;
   localparam int SW   = EW + 1;
   localparam int OW   = $clog2(WORD_BITS + 1);

   // request fields
   logic [OP_W-1:0]  req_op;
   logic [POS_W-1:0] req_start;
   logic [LEN_W-1:0] req_len;

   // control
   state_type        state_ff, state_in;
   logic [IW-1:0]    issue_ff, issue_in;   // next word to read (or to clear)
   logic [IW-1:0]    proc_ff, proc_in;     // word whose read data is arriving
   logic             rd_valid_ff, rd_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // transaction context
   logic [OP_W-1:0]  op_ff, op_in;
   logic [POS_W-1:0] start_ff, start_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [EW-1:0]    base_ff, base_in;     // first map bit of the word in proc_ff
   logic [LEN_W-1:0] carry_ff, carry_in;   // free run carried in from lower words

   // pending result and response register
   logic             res_found_ff, res_found_in;
   logic [POS_W-1:0] res_pos_ff, res_pos_in;
   logic             res_err_ff, res_err_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic             rsp_err_ff, rsp_err_in;

   // ram port
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [WORD_BITS-1:0] rd_data;

   // datapath
   scan_result_type      scan;
   logic [POS_W-1:0]     scan_pos;
   logic signed [SW-1:0] lo_off;
   logic signed [SW-1:0] hi_off;
   logic [OW-1:0]        lo_clip;
   logic [OW-1:0]        hi_clip;
   logic [WORD_BITS-1:0] mark_mask;
   logic                 last_word;
   logic                 len_zero;
   logic                 scan_big;
   logic                 mark_big;

   assign req_op    = req_tuser[OP_W-1:0];
   assign req_start = req_tdata[POS_W-1:0];
   assign req_len   = req_tdata[POS_W+LEN_W-1:POS_W];

   // clip a run boundary to the current word
   function automatic logic [OW-1:0] clip_off(input logic signed [SW-1:0] v);
      logic [OW-1:0] r;
      if (v < $signed(SW'(0))) begin
         r = '0;
      end else if (v > $signed(SW'(WORD_BITS))) begin
         r = OW'(WORD_BITS);
      end else begin
         r = v[OW-1:0];
      end
      return r;
   endfunction

   bra_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bra_scan_unit #(
      .WORD_BITS (WORD_BITS)
   ) u_scan (
      .word_data  (rd_data),
      .carry      (carry_ff),
      .run_length (len_ff),
      .result     (scan)
   );

   // start of the found run, kept modulo the position width
   assign scan_pos = base_ff[POS_W-1:0] + POS_W'(scan.index) + POS_W'(1) - len_ff[POS_W-1:0];

   // set/clear mask for the word being processed
   always_comb begin
      lo_off  = $signed(SW'(start_ff)) - $signed(SW'(base_ff));
      hi_off  = $signed(SW'(start_ff) + SW'(len_ff)) - $signed(SW'(base_ff));
      lo_clip = clip_off(lo_off);
      hi_clip = clip_off(hi_off);
      for (int j = 0; j < WORD_BITS; j++) begin
         mark_mask[j] = (OW'(j) >= lo_clip) && (OW'(j) < hi_clip);
      end
   end

   assign last_word = (proc_ff == IW'(MAP_WORDS - 1));
   assign len_zero  = (req_len == '0);
   assign scan_big  = (EW'(req_len) > EW'(TOTAL_BITS));
   assign mark_big  = ((EW'(req_start) + EW'(req_len)) > EW'(TOTAL_BITS));

   always_comb begin
      state_in     = state_ff;
      issue_in     = issue_ff;
      proc_in      = proc_ff;
      rd_valid_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      start_in     = start_ff;
      len_in       = len_ff;
      base_in      = base_ff;
      carry_in     = carry_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      res_err_in   = res_err_ff;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_err_in   = rsp_err_ff;
      wr_en        = 1'b0;
      wr_addr      = issue_ff[AW-1:0];
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = issue_ff[AW-1:0];

      // response register drains independently of the engine
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // read sweep, one word per cycle, data arrives in the following cycle
      if ((state_ff == ST_SCAN) || (state_ff == ST_MARK)) begin
         if (issue_ff < IW'(MAP_WORDS)) begin
            rd_en    = 1'b1;
            issue_in = issue_ff + IW'(1);
         end
         rd_valid_in = rd_en;
         proc_in     = issue_ff;
         if (rd_valid_ff) begin
            base_in = base_ff + EW'(WORD_BITS);
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (issue_ff == IW'(MAP_WORDS - 1)) begin
               issue_in = '0;
               state_in = ST_IDLE;
            end else begin
               issue_in = issue_ff + IW'(1);
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in        = req_op;
               start_in     = req_start;
               len_in       = req_len;
               issue_in     = '0;
               base_in      = '0;
               carry_in     = '0;
               res_found_in = 1'b0;
               res_pos_in   = '0;
               res_err_in   = 1'b0;
               case (req_op)
                  OP_SCAN: begin
                     res_err_in = len_zero || scan_big;
                     state_in   = (len_zero || scan_big) ? ST_DONE : ST_SCAN;
                  end
                  OP_SET, OP_CLEAR: begin
                     res_pos_in = req_start;
                     res_err_in = len_zero || mark_big;
                     state_in   = (len_zero || mark_big) ? ST_DONE : ST_MARK;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (rd_valid_ff) begin
               if (scan.hit) begin
                  res_found_in = 1'b1;
                  res_pos_in   = scan_pos;
                  state_in     = ST_DONE;
               end else if (last_word) begin
                  state_in = ST_DONE;
               end else begin
                  carry_in = scan.carry;
               end
            end
         end
         ST_MARK: begin
            if (rd_valid_ff) begin
               // read-modify-write; the next read is always a different word
               wr_en   = 1'b1;
               wr_addr = proc_ff[AW-1:0];
               if (op_ff == OP_SET) begin
                  wr_data = rd_data | mark_mask;
               end else begin
                  wr_data = rd_data & ~mark_mask;
               end
               if (last_word) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_pos_in   = res_pos_ff;
               rsp_err_in   = res_err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         issue_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_ff      <= proc_in;
      op_ff        <= op_in;
      start_ff     <= start_in;
      len_ff       <= len_in;
      base_ff      <= base_in;
      carry_ff     <= carry_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      res_err_ff   <= res_err_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - POS_W){1'b0}}, rsp_pos_ff};
   assign rsp_tuser  = {rsp_err_ff, rsp_found_ff};

endmodule

>>> rtl/bra_ram.sv
module bra_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bra_scan_unit.sv
module bra_scan_unit import bra_pkg::*; #(
   parameter int WORD_BITS = 64
) (
   input  logic [WORD_BITS-1:0] word_data,
   input  logic [LEN_W-1:0]     carry,
   input  logic [LEN_W-1:0]     run_length,
   output scan_result_type      result
);

   localparam int CW = LEN_W + 1;

   logic [WORD_BITS:0]   len_gt;
   logic [WORD_BITS-1:0] win_used;
   logic [WORD_BITS-1:0] carry_ok;
   logic [WORD_BITS-1:0] hit_vec;
   logic [IDX_W-1:0]     first_idx;
   logic [IDX_W-1:0]     top_used;
   logic [CW-1:0]        carry_sum;

   always_comb begin
      // thermometer of the run length
      for (int i = 0; i <= WORD_BITS; i++) begin
         len_gt[i] = (run_length > LEN_W'(i));
      end
      // window of run_length bits ending at bit j, cut at bit 0
      for (int j = 0; j < WORD_BITS; j++) begin
         win_used[j] = 1'b0;
         for (int k = 0; k <= j; k++) begin
            win_used[j] = win_used[j] | (word_data[k] & len_gt[j-k]);
         end
         carry_ok[j] = (CW'(carry) + CW'(j + 1)) >= CW'(run_length);
         hit_vec[j]  = !win_used[j] && (!len_gt[j+1] || carry_ok[j]);
      end
      // lowest hit
      first_idx = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (hit_vec[j]) begin
            first_idx = IDX_W'(j);
         end
      end
      // highest used bit
      top_used = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         if (word_data[j]) begin
            top_used = IDX_W'(j);
         end
      end
      carry_sum = CW'(carry) + CW'(WORD_BITS);
   end

   always_comb begin
      result.hit   = |hit_vec;
      result.index = first_idx;
      if (word_data == '0) begin
         result.carry = carry_sum[LEN_W-1:0];
      end else begin
         result.carry = LEN_W'(WORD_BITS - 1) - LEN_W'(top_used);
      end
   end

endmodule

>>> rtl/bra_checker.sv
module bra_checker import bra_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   // a stalled response holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // a response never reports both a found run and a range error
   a_found_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("found and range_error both set");

   // one transaction at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // clearing pass follows reset, so no request is taken right away
   a_clear: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("request ready during clearing pass");

endmodule

bind bitmap_run_allocator_top bra_checker u_bra_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
